FILE: src/kgs_pkg.sv
package kgs_pkg;

  localparam int COORD_W = 12;
  localparam int DIST_W = 7;
  localparam int GRID_W = 5;
  localparam int CFG_W = 12;
  localparam int CFG_IDX_W = 3;
  localparam int COUNT_W = 8;

  localparam int COARSE_W_MAX_DEF = 128;
  localparam int COARSE_H_MAX_DEF = 64;
  localparam int CELL_GRID_MAX_DEF = 16;
  localparam int BORDER_DEF = 10;

  localparam int DIV_STEPS = COORD_W;
  localparam int NEED_CAP = 20;

  localparam logic [COORD_W-1:0] COLS_RST = 12'd752;
  localparam logic [COORD_W-1:0] ROWS_RST = 12'd480;
  localparam logic [DIST_W-1:0] DIST_RST = 7'd10;
  localparam logic [GRID_W-1:0] ACROSS_RST = 5'd3;
  localparam logic [GRID_W-1:0] DOWN_RST = 5'd5;
  localparam logic [COORD_W-1:0] WANTED_RST = 12'd200;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_TRACK = 2'd1,
    ACT_END   = 2'd2,
    ACT_CAND  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    RSN_NONE    = 3'd0,
    RSN_BORDER  = 3'd1,
    RSN_COARSE  = 3'd2,
    RSN_CELL    = 3'd3,
    RSN_NEAR    = 3'd4,
    RSN_MASKED  = 3'd5
  } reason_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLS   = 3'd0,
    REG_ROWS   = 3'd1,
    REG_DIST   = 3'd2,
    REG_ACROSS = 3'd3,
    REG_DOWN   = 3'd4,
    REG_WANTED = 3'd5
  } reg_idx_t;

  typedef struct packed {
    action_t              action;
    logic [COORD_W-1:0]   px;
    logic [COORD_W-1:0]   py;
    logic                 masked;
  } item_t;

  typedef struct packed {
    logic                 kept;
    reason_t              reject_reason;
    logic [COUNT_W-1:0]   cell_count;
    logic [COORD_W-1:0]   kept_total;
    logic                 need_detection;
  } result_t;

endpackage

FILE: src/keypoint_grid_suppression_unit.sv
// Keypoint grid suppression.
// Items arrive on item/item_valid/item_ready; one result per item leaves on
// result/result_valid/result_ready. The user writes configuration through
// cfg_we/cfg_index/cfg_data only while no item is in flight; the block does
// not enforce this. Each transferred item passes through the bit-serial
// dividers (one quotient bit per cycle; four coarse and two cell-grid lanes
// run side by side), then one occupancy/count row read and one
// read-modify-write step before its result is posted.
// One item is in flight at a time: the next item is taken only once the
// block has posted the last result and returned to its idle state.
// The result sits in an output register; a stalled receiver holds the
// block in its decision state until the held result is transferred.
// Reset and every start_frame item run a clearing pass over the
// occupancy and cell-count rows; item_ready is low during the pass.
// start_frame returns its result before the pass begins. Configuration
// registers reset to their defaults and survive start_frame.
module keypoint_grid_suppression_unit #(
  parameter int COARSE_W_MAX = kgs_pkg::COARSE_W_MAX_DEF,
  parameter int COARSE_H_MAX = kgs_pkg::COARSE_H_MAX_DEF,
  parameter int CELL_GRID_MAX = kgs_pkg::CELL_GRID_MAX_DEF,
  parameter int BORDER = kgs_pkg::BORDER_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  kgs_pkg::item_t                     item,
  output logic                               result_valid,
  input  logic                               result_ready,
  output kgs_pkg::result_t                   result,
  input  logic                               cfg_we,
  input  logic [kgs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kgs_pkg::CFG_W-1:0]          cfg_data
);

  localparam int XW = kgs_pkg::COORD_W;
  localparam int DW = kgs_pkg::DIST_W;
  localparam int CNW = kgs_pkg::COUNT_W;
  localparam int ORB = (COARSE_H_MAX > 1) ? $clog2(COARSE_H_MAX) : 1;
  localparam int OCB = (COARSE_W_MAX > 1) ? $clog2(COARSE_W_MAX) : 1;
  localparam int QB = (CELL_GRID_MAX > 1) ? $clog2(CELL_GRID_MAX) : 1;
  localparam int GW = $clog2(CELL_GRID_MAX + 1);
  localparam int PW = XW + GW;
  localparam int SW = XW + QB;
  localparam int CLR_DEPTH = (COARSE_H_MAX > CELL_GRID_MAX) ? COARSE_H_MAX : CELL_GRID_MAX;
  localparam int CW = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;
  localparam int STW = $clog2(kgs_pkg::DIV_STEPS);
  localparam int CROW_W = CELL_GRID_MAX * CNW;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_DIV    = 5'b00100,
    S_READ   = 5'b01000,
    S_DECIDE = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [XW-1:0] image_cols, image_rows, wanted_features;
  logic [DW-1:0] min_distance;
  logic [kgs_pkg::GRID_W-1:0] cells_across, cells_down;

  kgs_pkg::item_t cur;
  logic [CW-1:0] clr_cnt;
  logic [STW-1:0] step;
  logic [XW-1:0] kept_count, kept_count_next;

  logic [XW-1:0] lane_q [4];
  logic [DW-1:0] lane_rem [4];
  logic [XW-1:0] lane_q_next [4];
  logic [DW-1:0] lane_rem_next [4];
  logic [DW:0] lane_trial [4];
  logic [DW:0] lane_diff [4];
  logic lane_ge [4];

  logic [PW-1:0] cprod [2];
  logic [PW-1:0] cprod_next [2];
  logic [SW-1:0] csh [2];
  logic [QB-1:0] cq [2];
  logic [QB-1:0] cq_next [2];
  logic cge [2];

  logic [COARSE_W_MAX-1:0] occ_mem [COARSE_H_MAX];
  logic [CROW_W-1:0] cell_mem [CELL_GRID_MAX];
  logic [COARSE_W_MAX-1:0] occ_rd, occ_wr;
  logic [CROW_W-1:0] cell_rd, cell_wr;

  logic [DW-1:0] spacing;
  logic [GW-1:0] gx, gy;
  logic [XW-1:0] xc, yc, wc, hc;
  logic [QB-1:0] xg, yg;
  logic border, out_coarse, out_cell, near;
  logic fire, item_xfer;
  logic occ_we, cell_we;
  logic [CNW-1:0] cnt_old, cnt_new;
  logic [XW-1:0] half, lim;
  logic signed [XW:0] needed;
  kgs_pkg::result_t res;

  function automatic logic [GW-1:0] clamp_grid(input logic [kgs_pkg::GRID_W-1:0] g);
    if (g == '0) return GW'(1);
    if (int'(g) > CELL_GRID_MAX) return GW'(CELL_GRID_MAX);
    return GW'(g);
  endfunction

  assign spacing = (min_distance == '0) ? DW'(1) : min_distance;
  assign gx = clamp_grid(cells_across);
  assign gy = clamp_grid(cells_down);
  assign item_ready = (state == S_IDLE);
  assign item_xfer = item_valid && item_ready;
  assign fire = (state == S_DECIDE) && (!result_valid || result_ready);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_cols <= kgs_pkg::COLS_RST;
      image_rows <= kgs_pkg::ROWS_RST;
      min_distance <= kgs_pkg::DIST_RST;
      cells_across <= kgs_pkg::ACROSS_RST;
      cells_down <= kgs_pkg::DOWN_RST;
      wanted_features <= kgs_pkg::WANTED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kgs_pkg::REG_COLS:   image_cols <= cfg_data[XW-1:0];
        kgs_pkg::REG_ROWS:   image_rows <= cfg_data[XW-1:0];
        kgs_pkg::REG_DIST:   min_distance <= cfg_data[DW-1:0];
        kgs_pkg::REG_ACROSS: cells_across <= cfg_data[kgs_pkg::GRID_W-1:0];
        kgs_pkg::REG_DOWN:   cells_down <= cfg_data[kgs_pkg::GRID_W-1:0];
        kgs_pkg::REG_WANTED: wanted_features <= cfg_data[XW-1:0];
        default: ;
      endcase
    end
  end

  // bit-serial restoring dividers: x/d, y/d, cols/d, rows/d, x*gx/cols, y*gy/rows
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lane_trial[i] = {lane_rem[i], lane_q[i][XW-1]};
      lane_diff[i] = lane_trial[i] - {1'b0, spacing};
      lane_ge[i] = (lane_trial[i] >= {1'b0, spacing});
      lane_rem_next[i] = lane_ge[i] ? lane_diff[i][DW-1:0] : lane_trial[i][DW-1:0];
      lane_q_next[i] = {lane_q[i][XW-2:0], lane_ge[i]};
    end
    for (int j = 0; j < 2; j++) begin
      cge[j] = (cprod[j] >= PW'(csh[j]));
      cprod_next[j] = cge[j] ? (cprod[j] - PW'(csh[j])) : cprod[j];
      cq_next[j] = QB'({cq[j], cge[j]});
    end
  end

  always_ff @(posedge clk) begin
    if (item_xfer) begin
      cur <= item;
      lane_q[0] <= item.px;
      lane_q[1] <= item.py;
      lane_q[2] <= image_cols;
      lane_q[3] <= image_rows;
      for (int i = 0; i < 4; i++) lane_rem[i] <= '0;
      cprod[0] <= PW'(item.px) * PW'(gx);
      cprod[1] <= PW'(item.py) * PW'(gy);
      csh[0] <= SW'(image_cols) << (QB - 1);
      csh[1] <= SW'(image_rows) << (QB - 1);
      cq[0] <= '0;
      cq[1] <= '0;
    end else if (state == S_DIV) begin
      for (int i = 0; i < 4; i++) begin
        lane_q[i] <= lane_q_next[i];
        lane_rem[i] <= lane_rem_next[i];
      end
      if (int'(step) < QB) begin
        for (int j = 0; j < 2; j++) begin
          cprod[j] <= cprod_next[j];
          csh[j] <= csh[j] >> 1;
          cq[j] <= cq_next[j];
        end
      end
    end
  end

  assign xc = lane_q[0];
  assign yc = lane_q[1];
  assign wc = lane_q[2];
  assign hc = lane_q[3];
  assign xg = cq[0];
  assign yg = cq[1];

  // occupancy and cell-count rows
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      if (int'(clr_cnt) < COARSE_H_MAX) occ_mem[clr_cnt[ORB-1:0]] <= '0;
      if (int'(clr_cnt) < CELL_GRID_MAX) cell_mem[clr_cnt[QB-1:0]] <= '0;
    end else begin
      if (occ_we) occ_mem[yc[ORB-1:0]] <= occ_wr;
      if (cell_we) cell_mem[yg] <= cell_wr;
    end
    if (state == S_READ) begin
      occ_rd <= occ_mem[yc[ORB-1:0]];
      cell_rd <= cell_mem[yg];
    end
  end

  // decision
  always_comb begin
    border = ({1'b0, cur.px} < (XW+1)'(BORDER)) ||
             (({1'b0, cur.px} + (XW+1)'(BORDER)) >= {1'b0, image_cols}) ||
             ({1'b0, cur.py} < (XW+1)'(BORDER)) ||
             (({1'b0, cur.py} + (XW+1)'(BORDER)) >= {1'b0, image_rows});
    out_coarse = (xc >= wc) || (int'(xc) >= COARSE_W_MAX) ||
                 (yc >= hc) || (int'(yc) >= COARSE_H_MAX);
    out_cell = (GW'(xg) >= gx) || (GW'(yg) >= gy);
    near = occ_rd[xc[OCB-1:0]];
    cnt_old = cell_rd[{xg, 3'b000} +: CNW];
    cnt_new = (cnt_old == '1) ? cnt_old : cnt_old + CNW'(1);
    occ_wr = occ_rd;
    occ_wr[xc[OCB-1:0]] = 1'b1;
    cell_wr = cell_rd;
    cell_wr[{xg, 3'b000} +: CNW] = cnt_new;
    half = {1'b0, wanted_features[XW-1:1]};
    lim = (int'(half) < kgs_pkg::NEED_CAP) ? half : XW'(kgs_pkg::NEED_CAP);
    needed = $signed({1'b0, wanted_features}) - $signed({1'b0, kept_count});

    res = '0;
    occ_we = 1'b0;
    cell_we = 1'b0;
    kept_count_next = kept_count;
    unique case (cur.action)
      kgs_pkg::ACT_START: begin
        kept_count_next = '0;
      end
      kgs_pkg::ACT_TRACK: begin
        if (border) res.reject_reason = kgs_pkg::RSN_BORDER;
        else if (out_coarse) res.reject_reason = kgs_pkg::RSN_COARSE;
        else if (out_cell) res.reject_reason = kgs_pkg::RSN_CELL;
        else if (near) res.reject_reason = kgs_pkg::RSN_NEAR;
        else if (cur.masked) res.reject_reason = kgs_pkg::RSN_MASKED;
        else begin
          res.kept = 1'b1;
          res.cell_count = cnt_new;
          occ_we = fire;
          cell_we = fire;
          if (kept_count != '1) kept_count_next = kept_count + XW'(1);
        end
      end
      kgs_pkg::ACT_END: begin
        res.need_detection = !(needed < $signed({1'b0, lim}));
      end
      kgs_pkg::ACT_CAND: begin
        if (out_coarse) res.reject_reason = kgs_pkg::RSN_COARSE;
        else if (near) res.reject_reason = kgs_pkg::RSN_NEAR;
        else begin
          res.kept = 1'b1;
          occ_we = fire;
        end
      end
    endcase
    res.kept_total = kept_count_next;
  end

  // control
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clr_cnt == CW'(CLR_DEPTH - 1)) state_next = S_IDLE;
      S_IDLE:   if (item_valid) state_next = S_DIV;
      S_DIV:    if (step == STW'(kgs_pkg::DIV_STEPS - 1)) state_next = S_READ;
      S_READ:   state_next = S_DECIDE;
      S_DECIDE: begin
        if (fire) state_next = (cur.action == kgs_pkg::ACT_START) ? S_CLEAR : S_IDLE;
      end
      default:  state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      step <= '0;
      kept_count <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + CW'(1);
      else clr_cnt <= '0;
      if (item_xfer) step <= '0;
      else if (state == S_DIV) step <= step + STW'(1);
      if (fire) begin
        kept_count <= kept_count_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) result <= res;
  end

`ifndef SYNTH
  a_kept_no_reason: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kept |-> result.reject_reason == kgs_pkg::RSN_NONE)
    else $error("kept result carries a reject reason");

  a_count_only_kept: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.cell_count != '0) |-> result.kept)
    else $error("cell count on a result that was not kept");

  a_rise_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_DECIDE))
    else $error("result posted outside the decision cycle");

  a_kept_monotonic: assert property (@(posedge clk) disable iff (rst)
    fire && (cur.action != kgs_pkg::ACT_START) |=> kept_count >= $past(kept_count))
    else $error("kept count decreased within a frame");

  a_clear_after_start: assert property (@(posedge clk) disable iff (rst)
    fire && (cur.action == kgs_pkg::ACT_START) |=> state == S_CLEAR && kept_count == '0)
    else $error("start_frame did not begin a clearing pass");
`endif

endmodule

FILE: dv/tb_keypoint_grid_suppression_unit.sv
module tb_keypoint_grid_suppression_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import kgs_pkg::*;

  localparam int CLEAR_WAIT = 96;
  localparam int OCC_DEPTH = COARSE_W_MAX_DEF * COARSE_H_MAX_DEF;
  localparam int TALLY_DEPTH = CELL_GRID_MAX_DEF * CELL_GRID_MAX_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  keypoint_grid_suppression_unit dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor copy of registers and frame state
  logic [COORD_W-1:0] cfg_cols = COLS_RST;
  logic [COORD_W-1:0] cfg_rows = ROWS_RST;
  logic [DIST_W-1:0] cfg_dist = DIST_RST;
  logic [GRID_W-1:0] cfg_across = ACROSS_RST;
  logic [GRID_W-1:0] cfg_down = DOWN_RST;
  logic [COORD_W-1:0] cfg_wanted = WANTED_RST;

  bit occ_map [OCC_DEPTH];
  logic [COUNT_W-1:0] cell_tally [TALLY_DEPTH];
  logic [COORD_W-1:0] kept_tally;

  result_t pending_results [$];

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int n_items = 0;
  int n_frames = 0;
  int n_writes = 0;
  int n_checked = 0;
  int n_kept = 0;
  int mismatches = 0;

  function automatic void clear_frame_model();
    foreach (occ_map[i]) occ_map[i] = 1'b0;
    foreach (cell_tally[i]) cell_tally[i] = '0;
    kept_tally = '0;
  endfunction

  function automatic int clamp_cells(logic [GRID_W-1:0] g);
    if (g == '0) return 1;
    if (int'(g) > CELL_GRID_MAX_DEF) return CELL_GRID_MAX_DEF;
    return int'(g);
  endfunction

  function automatic result_t filter_keypoint(item_t it);
    result_t r;
    int x, y, cols, rows, d, cw, ch, xc, yc, cidx, gx, gy, xg, yg, gi, needed, lim;
    bit in_coarse;
    r = '0;
    x = int'(it.px);
    y = int'(it.py);
    cols = int'(cfg_cols);
    rows = int'(cfg_rows);
    d = (cfg_dist == '0) ? 1 : int'(cfg_dist);
    cw = cols / d;
    ch = rows / d;
    if (cw > COARSE_W_MAX_DEF) cw = COARSE_W_MAX_DEF;
    if (ch > COARSE_H_MAX_DEF) ch = COARSE_H_MAX_DEF;
    xc = x / d;
    yc = y / d;
    in_coarse = (xc < cw) && (yc < ch);
    cidx = in_coarse ? yc * COARSE_W_MAX_DEF + xc : 0;
    gx = clamp_cells(cfg_across);
    gy = clamp_cells(cfg_down);
    xg = 0;
    yg = 0;
    case (it.action)
      ACT_START: clear_frame_model();
      ACT_TRACK: begin
        if (x < BORDER_DEF || x >= cols - BORDER_DEF ||
            y < BORDER_DEF || y >= rows - BORDER_DEF) begin
          r.reject_reason = RSN_BORDER;
        end else if (!in_coarse) begin
          r.reject_reason = RSN_COARSE;
        end else begin
          xg = (x * gx) / cols;
          yg = (y * gy) / rows;
          if (xg >= gx || yg >= gy) r.reject_reason = RSN_CELL;
          else if (occ_map[cidx]) r.reject_reason = RSN_NEAR;
          else if (it.masked) r.reject_reason = RSN_MASKED;
        end
        if (r.reject_reason == RSN_NONE) begin
          gi = yg * CELL_GRID_MAX_DEF + xg;
          occ_map[cidx] = 1'b1;
          if (cell_tally[gi] != 8'd255) cell_tally[gi] = cell_tally[gi] + 1'b1;
          if (kept_tally != 12'd4095) kept_tally = kept_tally + 1'b1;
          r.kept = 1'b1;
          r.cell_count = cell_tally[gi];
        end
      end
      ACT_END: begin
        needed = int'(cfg_wanted) - int'(kept_tally);
        lim = int'(cfg_wanted) / 2;
        if (lim > NEED_CAP) lim = NEED_CAP;
        r.need_detection = (needed >= lim);
      end
      ACT_CAND: begin
        if (!in_coarse) begin
          r.reject_reason = RSN_COARSE;
        end else if (occ_map[cidx]) begin
          r.reject_reason = RSN_NEAR;
        end else begin
          occ_map[cidx] = 1'b1;
          r.kept = 1'b1;
        end
      end
    endcase
    r.kept_total = kept_tally;
    return r;
  endfunction

  function automatic item_t make_item(action_t a, int x, int y, bit m);
    item_t it;
    it.action = a;
    it.px = 12'(x);
    it.py = 12'(y);
    it.masked = m;
    return it;
  endfunction

  // mostly inside the image, often clustered to hit occupied cells
  function automatic int pick_coord(int span);
    int d_eff, sel, hi;
    d_eff = (cfg_dist == '0) ? 1 : int'(cfg_dist);
    sel = $urandom_range(0, 99);
    if (sel < 8) return $urandom_range(0, 4095);
    if (sel < 50) begin
      hi = (span + 4 > 4095) ? 4095 : span + 4;
      return $urandom_range(0, hi);
    end
    hi = BORDER_DEF + 4 * d_eff;
    if (hi > 4095) hi = 4095;
    return $urandom_range(BORDER_DEF, hi);
  endfunction

  function automatic item_t noise_item();
    return make_item(action_t'($urandom_range(0, 3)), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), $urandom_range(0, 1));
  endfunction

  always @(negedge clk) begin
    result_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing pending");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (result.kept) n_kept++;
        if (result.kept !== want.kept) begin
          $error("kept: expected %0d, got %0d", want.kept, result.kept);
          mismatches++;
        end
        if (result.reject_reason !== want.reject_reason) begin
          $error("reject_reason: expected %0d, got %0d", want.reject_reason,
                 result.reject_reason);
          mismatches++;
        end
        if (result.cell_count !== want.cell_count) begin
          $error("cell_count: expected %0d, got %0d", want.cell_count, result.cell_count);
          mismatches++;
        end
        if (result.kept_total !== want.kept_total) begin
          $error("kept_total: expected %0d, got %0d", want.kept_total, result.kept_total);
          mismatches++;
        end
        if (result.need_detection !== want.need_detection) begin
          $error("need_detection: expected %0d, got %0d", want.need_detection,
                 result.need_detection);
          mismatches++;
        end
      end
    end
  end

  task automatic send_keypoint(item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    pending_results = {pending_results, filter_keypoint(it)};
    n_items++;
    if (it.action == ACT_START) n_frames++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 12'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_COLS:   cfg_cols = 12'(val);
      REG_ROWS:   cfg_rows = 12'(val);
      REG_DIST:   cfg_dist = 7'(val);
      REG_ACROSS: cfg_across = 5'(val);
      REG_DOWN:   cfg_down = 5'(val);
      REG_WANTED: cfg_wanted = 12'(val);
      default: ;
    endcase
    n_writes++;
  endtask

  // block must be idle, including any clearing pass after start_frame
  task automatic apply_config(int cols, int rows, int dist_val, int across, int down,
                              int wanted);
    drain_results();
    repeat (CLEAR_WAIT) @(posedge clk);
    write_reg(REG_COLS, cols);
    write_reg(REG_ROWS, rows);
    write_reg(REG_DIST, dist_val);
    write_reg(REG_ACROSS, across);
    write_reg(REG_DOWN, down);
    write_reg(REG_WANTED, wanted);
  endtask

  task automatic run_frame(int n_track, int n_cand, bit pause_mid);
    send_keypoint(make_item(ACT_START, 0, 0, 1'b0));
    for (int i = 0; i < n_track; i++) begin
      if (pause_mid && i == n_track / 2) drain_results();
      if ($urandom_range(0, 99) < 10) send_keypoint(noise_item());
      else send_keypoint(make_item(ACT_TRACK, pick_coord(int'(cfg_cols)),
                                   pick_coord(int'(cfg_rows)), $urandom_range(0, 99) < 20));
    end
    send_keypoint(make_item(ACT_END, $urandom_range(0, 4095), $urandom_range(0, 4095),
                            $urandom_range(0, 1)));
    for (int i = 0; i < n_cand; i++) begin
      if ($urandom_range(0, 99) < 10) send_keypoint(noise_item());
      else send_keypoint(make_item(ACT_CAND, pick_coord(int'(cfg_cols)),
                                   pick_coord(int'(cfg_rows)), $urandom_range(0, 1)));
    end
  endtask

  task automatic test_reset_defaults();
    src_idle_pct = 29;
    sink_stall_pct = 29;
    send_keypoint(make_item(ACT_START, 0, 0, 1'b0));
    send_keypoint(make_item(ACT_TRACK, 10, 10, 1'b0));
    send_keypoint(make_item(ACT_TRACK, 15, 15, 1'b0));
    send_keypoint(make_item(ACT_TRACK, 9, 100, 1'b0));
    send_keypoint(make_item(ACT_TRACK, 742, 100, 1'b0));
    send_keypoint(make_item(ACT_TRACK, 741, 469, 1'b0));
    send_keypoint(make_item(ACT_TRACK, 100, 9, 1'b0));
    send_keypoint(make_item(ACT_TRACK, 100, 470, 1'b0));
    send_keypoint(make_item(ACT_TRACK, 200, 200, 1'b1));
    send_keypoint(make_item(ACT_TRACK, 200, 200, 1'b0));
    send_keypoint(make_item(ACT_TRACK, 0, 0, 1'b0));
    send_keypoint(make_item(ACT_TRACK, 4095, 4095, 1'b1));
    send_keypoint(make_item(ACT_END, 4095, 4095, 1'b1));
    send_keypoint(make_item(ACT_CAND, 205, 205, 1'b0));
    send_keypoint(make_item(ACT_CAND, 300, 300, 1'b1));
    send_keypoint(make_item(ACT_CAND, 300, 300, 1'b0));
    send_keypoint(make_item(ACT_CAND, 4095, 4095, 1'b0));
    send_keypoint(make_item(ACT_CAND, 0, 0, 1'b0));
    send_keypoint(make_item(ACT_CAND, 751, 479, 1'b0));
    send_keypoint(make_item(ACT_TRACK, 20, 20, 1'b0));
    send_keypoint(make_item(ACT_START, 4095, 4095, 1'b1));
    send_keypoint(make_item(ACT_END, 0, 0, 1'b0));
  endtask

  task automatic test_register_extremes();
    src_idle_pct = 58;
    sink_stall_pct = 0;
    // coarse grid narrower than the border window; kept count above wanted
    apply_config(100, 100, 40, 0, 31, 0);
    send_keypoint(make_item(ACT_START, 0, 0, 1'b0));
    send_keypoint(make_item(ACT_TRACK, 85, 50, 1'b0));
    send_keypoint(make_item(ACT_END, 0, 0, 1'b0));
    run_frame(12, 6, 1'b0);
    // zero spacing acts as 1, coarse grid clamped
    src_idle_pct = 0;
    sink_stall_pct = 58;
    apply_config(4095, 4095, 0, 31, 0, 1);
    send_keypoint(make_item(ACT_START, 0, 0, 1'b0));
    send_keypoint(make_item(ACT_TRACK, 200, 20, 1'b0));
    send_keypoint(make_item(ACT_CAND, 20, 100, 1'b0));
    run_frame(12, 6, 1'b0);
    // zero image size
    apply_config(0, 0, 127, 16, 16, 4095);
    send_keypoint(make_item(ACT_START, 0, 0, 1'b0));
    send_keypoint(make_item(ACT_TRACK, 50, 50, 1'b0));
    send_keypoint(make_item(ACT_CAND, 0, 0, 1'b0));
    run_frame(6, 4, 1'b0);
    // need_detection threshold around the cap
    src_idle_pct = 29;
    sink_stall_pct = 29;
    apply_config(4095, 4095, 127, 16, 16, 40);
    run_frame(24, 6, 1'b0);
    apply_config(4095, 4095, 64, 1, 1, 41);
    run_frame(24, 6, 1'b0);
  endtask

  // drives the cell count into saturation
  task automatic test_saturation();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    apply_config(4095, 4095, 1, 0, 0, 4095);
    send_keypoint(make_item(ACT_START, 0, 0, 1'b0));
    for (int i = 0; i < 300; i++) begin
      send_keypoint(make_item(ACT_TRACK, BORDER_DEF + i % 118, BORDER_DEF + i / 118, 1'b0));
    end
    send_keypoint(make_item(ACT_END, 0, 0, 1'b0));
    send_keypoint(make_item(ACT_TRACK, 10, 10, 1'b0));
    send_keypoint(make_item(ACT_CAND, 127, 63, 1'b0));
    send_keypoint(make_item(ACT_START, 0, 0, 1'b0));
  endtask

  task automatic test_random_frames();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 58; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 58; end
        default: begin src_idle_pct = 29; sink_stall_pct = 29; end
      endcase
      for (int c = 0; c < 2; c++) begin
        if ($urandom_range(0, 3) == 0) begin
          apply_config($urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 127), $urandom_range(0, 31),
                       $urandom_range(0, 31), $urandom_range(0, 4095));
        end else begin
          apply_config($urandom_range(20, 800), $urandom_range(20, 600),
                       $urandom_range(1, 40), $urandom_range(1, 16),
                       $urandom_range(1, 16), $urandom_range(0, 80));
        end
        for (int f = 0; f < 2; f++) begin
          run_frame($urandom_range(10, 50), $urandom_range(4, 20), (c == 0 && f == 0));
        end
      end
    end
  endtask

  initial begin
    clear_frame_model();
    rst = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_register_extremes();
    test_saturation();
    test_random_frames();
    drain_results();
    repeat (CLEAR_WAIT) @(posedge clk);
    $display("Covered %0d item transfers over %0d frames, %0d register writes",
             n_items, n_frames, n_writes);
    $display("%0d results compared (%0d kept), %0d mismatches", n_checked, n_kept,
             mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
